FILE: hdl/spimq_pkg.sv
// Shared types and constants for the SPI master byte queue block.
// No dependencies; imported by every module of the block.
`default_nettype none

package spimq_pkg;

    // Input item kind codes as they arrive on the stream
    localparam logic [1:0] KIND_TICK       = 2'd0;
    localparam logic [1:0] KIND_PUSH_DATA  = 2'd1;
    localparam logic [1:0] KIND_PUSH_BREAK = 2'd2;

    // Configuration register index (taken from paddr[2])
    localparam logic REG_HALF_PERIOD = 1'b0;

    localparam logic [7:0] HALF_PERIOD_RESET = 8'd10;
    localparam logic [7:0] IDLE_BYTE         = 8'hFF;
    localparam int         QUEUE_DEPTH_DEF   = 16;
    localparam int         CMD_DEPTH         = 2;

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_PUSH_DATA  = 2'd1,
        OP_PUSH_BREAK = 2'd2,
        OP_NOP        = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic       miso;
    } t_cmd;

    typedef struct packed {
        logic       push_dropped;
        logic       busy_res;
        logic       received_valid;
        logic [7:0] received_byte;
        logic       data_line;
        logic       clock_line;
        logic       select_line;
    } t_result;

endpackage

`default_nettype wire

FILE: hdl/spimq_front.sv
// Front end: classifies incoming items into commands and buffers them
// in a short command queue. Depends on spimq_pkg.
`default_nettype none

module spimq_front import spimq_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output      logic       o_ready,
    input  wire logic [1:0] i_kind,
    input  wire logic [7:0] i_data,
    input  wire logic       i_miso,
    output      t_cmd       o_cmd,
    output      logic       o_cmd_valid,
    input  wire logic       i_cmd_pop
);

    localparam int PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CW = $clog2(CMD_DEPTH + 1);

    t_cmd           r_slot [CMD_DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count,  n_count;
    t_cmd           w_cmd;
    logic           w_push;

    always_comb begin
        w_cmd.data = i_data;
        w_cmd.miso = i_miso;
        unique case (i_kind)
            KIND_TICK:       w_cmd.op = OP_TICK;
            KIND_PUSH_DATA:  w_cmd.op = OP_PUSH_DATA;
            KIND_PUSH_BREAK: w_cmd.op = OP_PUSH_BREAK;
            default:         w_cmd.op = OP_NOP;
        endcase
    end

    assign o_ready     = (r_count != CW'(CMD_DEPTH));
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(CMD_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_cmd_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(CMD_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        priority if (w_push && !i_cmd_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && i_cmd_pop) begin
            n_count = r_count - 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/spimq_engine.sv
// Back end: byte queue memory, half-period divider, serial shifters and
// the registered result stage. Depends on spimq_pkg.
`default_nettype none

module spimq_engine import spimq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_half_period,
    input  wire t_cmd       i_cmd,
    input  wire logic       i_cmd_valid,
    output      logic       o_cmd_pop,
    output      t_result    o_res,
    output      logic       o_res_valid,
    input  wire logic       i_res_ready
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [8:0]     r_mem [QUEUE_DEPTH];
    logic [8:0]     r_head_data;

    logic [7:0]     r_tick_count, n_tick_count;
    logic           r_cs,   n_cs;
    logic           r_sclk, n_sclk;
    logic           r_dout, n_dout;
    logic [2:0]     r_bit,  n_bit;
    logic [7:0]     r_tx,   n_tx;
    logic [7:0]     r_rx,   n_rx;
    logic [AW-1:0]  r_head, n_head;
    logic [AW-1:0]  r_tail, n_tail;
    logic [CW-1:0]  r_count, n_count;
    t_result        r_res,  n_res;
    logic           r_res_valid;

    logic           w_we;
    logic [8:0]     w_entry;
    logic [7:0]     w_tx_load;

    assign o_cmd_pop   = i_cmd_valid && (!r_res_valid || i_res_ready);
    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

    always_comb begin
        n_tick_count = r_tick_count;
        n_cs         = r_cs;
        n_sclk       = r_sclk;
        n_dout       = r_dout;
        n_bit        = r_bit;
        n_tx         = r_tx;
        n_rx         = r_rx;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        w_we         = 1'b0;
        w_entry      = {1'b1, 8'h00};
        w_tx_load    = r_tx;
        n_res        = '0;

        unique case (i_cmd.op)
            OP_PUSH_DATA, OP_PUSH_BREAK: begin
                w_entry = (i_cmd.op == OP_PUSH_DATA) ? {1'b0, i_cmd.data} : {1'b1, 8'h00};
                if (r_count == CW'(QUEUE_DEPTH)) begin
                    n_res.push_dropped = 1'b1;
                end else begin
                    w_we    = 1'b1;
                    n_tail  = (r_tail == AW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            OP_TICK: begin
                if (r_tick_count <= 8'd1) begin
                    n_tick_count = i_half_period;
                    if (r_sclk) begin
                        n_sclk = 1'b0;
                        if (r_bit == 3'd0) begin
                            if (!r_cs) begin
                                n_res.received_byte  = r_rx;
                                n_res.received_valid = 1'b1;
                            end
                            if (r_count == '0) begin
                                n_cs      = 1'b1;
                                w_tx_load = IDLE_BYTE;
                            end else begin
                                n_head  = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                                n_count = r_count - 1'b1;
                                if (r_head_data[8]) begin
                                    n_cs      = 1'b1;
                                    w_tx_load = IDLE_BYTE;
                                end else begin
                                    n_cs      = 1'b0;
                                    w_tx_load = r_head_data[7:0];
                                end
                            end
                        end
                        n_dout = w_tx_load[7];
                        n_tx   = {w_tx_load[6:0], 1'b0};
                        n_bit  = r_bit + 3'd1;
                    end else begin
                        n_sclk = 1'b1;
                        n_rx   = {r_rx[6:0], i_cmd.miso};
                    end
                end else begin
                    n_tick_count = r_tick_count - 8'd1;
                end
            end
            default: begin
            end
        endcase

        n_res.select_line = n_cs;
        n_res.clock_line  = n_sclk;
        n_res.data_line   = n_dout;
        n_res.busy_res    = !n_cs || (n_count != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= HALF_PERIOD_RESET;
            r_cs         <= 1'b1;
            r_sclk       <= 1'b1;
            r_dout       <= 1'b1;
            r_bit        <= '0;
            r_tx         <= '0;
            r_rx         <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_res_valid  <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_tick_count <= n_tick_count;
                r_cs         <= n_cs;
                r_sclk       <= n_sclk;
                r_dout       <= n_dout;
                r_bit        <= n_bit;
                r_tx         <= n_tx;
                r_rx         <= n_rx;
                r_head       <= n_head;
                r_tail       <= n_tail;
                r_count      <= n_count;
                r_res_valid  <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_res <= n_res;
        end
    end

    // Queue memory with head prefetch; a write landing on the next head
    // address is forwarded so an empty-queue push is seen next cycle.
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && w_we) begin
            r_mem[r_tail] <= w_entry;
        end
        if (o_cmd_pop && w_we && (r_tail == n_head)) begin
            r_head_data <= w_entry;
        end else if (o_cmd_pop) begin
            r_head_data <= r_mem[n_head];
        end else begin
            r_head_data <= r_mem[r_head];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/spi_master_byte_queue_core.sv
// Top level of the SPI master byte queue: stream ports, APB register,
// front classifier/command queue and back-end engine. Depends on spimq_pkg.
`default_nettype none

// Channel   Direction  Handshake                    Payload
// s_*       in         s_tvalid / s_tready          tuser kind, tdata data+miso
// m_*       out        m_tvalid / m_tready          tdata result fields
// APB       in         psel & penable & pwrite      half_period at address 0
//
// One item per clock sustained while m_tready does not stall; each item produces exactly one result.
// Each item passes through the command queue, then the result register.
// The engine step (divider, shifters, queue memory port) is combinational between the two.
// Reset is synchronous, active low; the queue memory is not cleared.
// A stalled m_tready backs up the result register, then the two-entry
// command queue, then s_tready drops.

module spi_master_byte_queue_core import spimq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] data, [8] miso_bit, [15:9] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] kind
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [15:0] m_tdata,   // [0] select_line, [1] clock_line, [2] data_line,
                                        // [10:3] received_byte, [11] received_valid,
                                        // [12] busy_res, [13] push_dropped, [15:14] zero
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    logic [7:0] r_half_period;
    logic       w_cfg_wr;
    t_cmd       w_cmd;
    logic       w_cmd_valid;
    logic       w_cmd_pop;
    t_result    w_res;

    // APB register file: one 8-bit register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_HALF_PERIOD) ? {24'd0, r_half_period} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RESET;
        end else if (w_cfg_wr && (paddr[2] == REG_HALF_PERIOD)) begin
            r_half_period <= pwdata[7:0];
        end
    end

    spimq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_tvalid),
        .o_ready     (s_tready),
        .i_kind      (s_tuser),
        .i_data      (s_tdata[7:0]),
        .i_miso      (s_tdata[8]),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop)
    );

    spimq_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_half_period (r_half_period),
        .i_cmd         (w_cmd),
        .i_cmd_valid   (w_cmd_valid),
        .o_cmd_pop     (w_cmd_pop),
        .o_res         (w_res),
        .o_res_valid   (m_tvalid),
        .i_res_ready   (m_tready)
    );

    assign m_tdata = {2'b00, w_res.push_dropped, w_res.busy_res, w_res.received_valid,
                      w_res.received_byte, w_res.data_line, w_res.clock_line,
                      w_res.select_line};

`ifndef SYNTH
    // Command queue comes out of reset empty and ready
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> s_tready)
        else $error("s_tready low right after reset");

    // A held result must stall the engine
    a_no_pop_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |-> !w_cmd_pop)
        else $error("engine advanced while result stalled");

    // Engine only consumes commands that exist
    a_pop_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_cmd_valid)
        else $error("pop from empty command queue");

    // Byte boundaries fall on serial clock falling edges
    a_rx_on_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && w_res.received_valid) |-> !w_res.clock_line)
        else $error("received byte reported with serial clock high");
`endif

endmodule

`default_nettype wire
